// ===== hdl/hdsc_pkg.sv =====
`timescale 1ns / 1ps
package hdsc_pkg;

  // input selector codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_RECORD = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DUE     = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_OVERDUE = 2'd3;

  // register word addresses (paddr bit 2)
  localparam logic REG_SCAN_INTERVAL  = 1'b0;
  localparam logic REG_SAFE_GAP_LIMIT = 1'b1;

  localparam logic [31:0] SCAN_INTERVAL_RST  = 32'd1000;
  localparam logic [31:0] SAFE_GAP_LIMIT_RST = 32'd5000;

  // saturation ceiling of the 48-bit result fields
  localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic       emit;
    logic [1:0] status;
    logic       last;
    logic       lag_zero;
    logic       set_safe;
    logic       store_scan;
  } hdsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic now_pos;
    logic safe;
    logic gap_over;
    logic hit;
    logic out_free;
  } hdsc_sts_t;

endpackage

// ===== hdl/hdsc_cfg.sv =====
`timescale 1ns / 1ps
module hdsc_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [31:0] scan_interval,
  output logic [31:0] safe_gap_limit
);
  import hdsc_pkg::*;

  logic [31:0] scan_interval_r;
  logic [31:0] safe_gap_limit_r;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_interval_r  <= SCAN_INTERVAL_RST;
      safe_gap_limit_r <= SAFE_GAP_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_SCAN_INTERVAL) begin
        scan_interval_r <= pwdata;
      end else begin
        safe_gap_limit_r <= pwdata;
      end
    end
  end

  // read mux
  assign prdata = (paddr[2] == REG_SAFE_GAP_LIMIT) ? safe_gap_limit_r : scan_interval_r;

  assign scan_interval  = scan_interval_r;
  assign safe_gap_limit = safe_gap_limit_r;

endmodule

// ===== hdl/hdsc_dp.sv =====
`timescale 1ns / 1ps
module hdsc_dp #(
  parameter int SCAN_N    = 16,
  parameter int IDX_W     = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          in_func,
  input  logic [3:0]          in_entity,
  input  logic [47:0]         in_deadline,
  input  logic [47:0]         in_now,
  input  logic [31:0]         scan_interval,
  input  logic [31:0]         safe_gap_limit,
  input  hdsc_pkg::hdsc_cmd_t cmd,
  input  logic [IDX_W-1:0]    idx,
  output hdsc_pkg::hdsc_sts_t sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [3:0]          out_entity,
  output logic [47:0]         out_overdue,
  output logic [47:0]         out_lag,
  output logic                out_safe,
  output logic                out_last
);
  import hdsc_pkg::*;

  localparam int SAT_W = (TIME_BITS > 48) ? TIME_BITS : 48;

  // deadline table, entries undefined until recorded
  logic signed [TIME_BITS-1:0] store_r [SCAN_N];
  logic [SCAN_N-1:0]           valid_r;

  logic signed [TIME_BITS-1:0] now_r;
  logic signed [TIME_BITS-1:0] last_scan_r;
  logic                        safe_r;
  logic [TIME_BITS-1:0]        gap_r;
  logic [47:0]                 lag_r;
  logic                        gap_over_r;

  logic signed [TIME_BITS-1:0] dl_in;
  logic signed [TIME_BITS-1:0] now_in;
  logic                        ent_ok;
  logic [IDX_W-1:0]            ent_idx;

  assign dl_in   = TIME_BITS'($signed(in_deadline));
  assign now_in  = TIME_BITS'($signed(in_now));
  assign ent_ok  = ({1'b0, in_entity} < 5'(SCAN_N));
  assign ent_idx = in_entity[IDX_W-1:0];

  // record and clear items
  always_ff @(posedge clk) begin
    if (in_accept && in_func == FUNC_RECORD && ent_ok) begin
      store_r[ent_idx] <= dl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (in_accept && ent_ok) begin
      if (in_func == FUNC_RECORD) begin
        valid_r[ent_idx] <= 1'b1;
      end else if (in_func == FUNC_CLEAR) begin
        valid_r[ent_idx] <= 1'b0;
      end
    end
  end

  // tick time capture
  always_ff @(posedge clk) begin
    if (in_accept && in_func == FUNC_TICK) begin
      now_r <= now_in;
    end
  end

  // scan time and safe latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_scan_r <= '0;
      safe_r      <= 1'b0;
    end else begin
      if (cmd.store_scan) begin
        last_scan_r <= now_r;
      end
      if (cmd.set_safe) begin
        safe_r <= 1'b1;
      end
    end
  end

  // gap since last scan, then lag and safe limit check registered from the gap
  logic [TIME_BITS-1:0] iv_ext;
  logic [TIME_BITS-1:0] lim_ext;
  logic [TIME_BITS-1:0] lag_raw;
  logic [SAT_W-1:0]     lag_ext;
  logic                 have_last;
  logic                 gap_pos;
  logic [47:0]          lag_nxt;

  assign iv_ext    = TIME_BITS'(scan_interval);
  assign lim_ext   = TIME_BITS'(safe_gap_limit);
  assign have_last = (last_scan_r != '0);
  // a tick earlier than the last scan gives a negative gap
  assign gap_pos   = !gap_r[TIME_BITS-1];
  assign lag_raw   = gap_r - iv_ext;
  assign lag_ext   = SAT_W'(lag_raw);

  always_comb begin
    lag_nxt = '0;
    if (have_last && gap_pos && gap_r > iv_ext) begin
      lag_nxt = (lag_ext > SAT_W'(OUT_MAX)) ? OUT_MAX : lag_ext[47:0];
    end
  end

  always_ff @(posedge clk) begin
    gap_r      <= now_r - last_scan_r;
    lag_r      <= lag_nxt;
    gap_over_r <= have_last && gap_pos && (gap_r > lim_ext);
  end

  // due check of the entry under the scan index
  logic signed [TIME_BITS:0]   diff;
  logic signed [TIME_BITS-1:0] dl_cur;
  logic [SAT_W-1:0]            od_ext;
  logic [47:0]                 od_sat;

  assign dl_cur = store_r[idx];
  assign diff   = {now_r[TIME_BITS-1], now_r} - {dl_cur[TIME_BITS-1], dl_cur};
  assign od_ext = SAT_W'(diff[TIME_BITS-1:0]);
  assign od_sat = (od_ext > SAT_W'(OUT_MAX)) ? OUT_MAX : od_ext[47:0];

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_entity_r;
  logic [47:0] out_overdue_r;
  logic [47:0] out_lag_r;
  logic        out_safe_r;
  logic        out_last_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= cmd.status;
      out_entity_r  <= (cmd.status == ST_DUE) ? 4'(idx) : 4'd0;
      out_overdue_r <= (cmd.status == ST_DUE) ? od_sat : 48'd0;
      out_lag_r     <= cmd.lag_zero ? 48'd0 : lag_r;
      out_safe_r    <= safe_r || cmd.set_safe;
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_entity  = out_entity_r;
  assign out_overdue = out_overdue_r;
  assign out_lag     = out_lag_r;
  assign out_safe    = out_safe_r;
  assign out_last    = out_last_r;

  // status back to the controller
  assign sts.now_pos  = !now_r[TIME_BITS-1] && (now_r != '0);
  assign sts.safe     = safe_r;
  assign sts.gap_over = gap_over_r;
  assign sts.hit      = valid_r[idx] && !diff[TIME_BITS];
  assign sts.out_free = out_free;

endmodule

// ===== hdl/hdsc_ctrl.sv =====
`timescale 1ns / 1ps
module hdsc_ctrl #(
  parameter int SCAN_N = 16,
  parameter int IDX_W  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          in_func,
  output logic                in_ready,
  input  hdsc_pkg::hdsc_sts_t sts,
  output hdsc_pkg::hdsc_cmd_t cmd,
  output logic [IDX_W-1:0]    idx
);
  import hdsc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAP    = 3'd1;
  localparam logic [2:0] S_LAG    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SCAN_N - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.status   = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_accept && in_func == FUNC_TICK) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        state_nxt = S_LAG;
      end
      S_LAG: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (!sts.now_pos) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.status   = ST_INVALID;
            cmd.last     = 1'b1;
            cmd.lag_zero = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.safe) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.status   = ST_OVERDUE;
            cmd.last     = 1'b1;
            cmd.lag_zero = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.gap_over) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.status   = ST_OVERDUE;
            cmd.last     = 1'b1;
            cmd.set_safe = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.hit || sts.out_free) begin
          if (sts.hit) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_DUE;
          end
          if (idx_r == IDX_END) begin
            state_nxt = S_FINAL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.status     = ST_DONE;
          cmd.last       = 1'b1;
          cmd.store_scan = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register busy");

  // the final result of a tick returns the controller to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("tick not finished after last result");

  // scan index stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= IDX_END))
    else $error("scan index out of range");

  // the safe latch only sets together with an overdue result
  a_safe_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_safe |-> (cmd.emit && cmd.status == ST_OVERDUE))
    else $error("safe latch set without overdue result");

  // scan time is stored only when the done result goes out
  a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_scan |-> (state_r == S_FINAL && cmd.emit && !sts.safe))
    else $error("scan time stored outside final step");

endmodule

// ===== hdl/heartbeat_deadline_scanner.sv =====
`timescale 1ns / 1ps
// Watchdog deadline table with a periodic scan.
// Input stream: in_tuser selects the item (tick, record, clear); in_tdata
// carries entity, deadline and current time. Record and clear beats produce
// nothing. A tick walks the table one entry per cycle, holding while a due
// result waits for the output register, and emits one beat per due entity
// followed by a done beat (out_tlast high), or a single invalid-time or
// overdue beat.
// A tick steps through the gap, lag and decision states; a special-case
// result is loaded from the decision state, while a scan walks ENTITIES
// entries (capped at 16) and then a final state emits the done beat.
// in_tready is high only between items; the last result may still sit in the
// output register while the next item is taken.
// When the receiver stalls, the scan holds on the pending result until
// the output register drains; nothing is dropped.
// Reset clears the valid bits, the last scan time and the safe latch, and
// loads the default scan interval and safe gap limit. Stored deadlines are
// not cleared. Registers sit on an APB port: scan_interval at 0x0,
// safe_gap_limit at 0x4.
module heartbeat_deadline_scanner #(
  parameter int ENTITIES  = 16,
  parameter int TIME_BITS = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // entity[3:0], deadline_time[51:4], now_time[99:52]
  input  logic [1:0]   in_tuser,  // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata, // due_entity[3:0], overdue_by[51:4], scan_lag[99:52],
                                  // safe_mode[100]
  output logic [1:0]   out_tuser, // status[1:0]
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import hdsc_pkg::*;

  localparam int SCAN_N = (ENTITIES < 16) ? ENTITIES : 16;
  localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

  logic             in_accept;
  hdsc_cmd_t        cmd;
  hdsc_sts_t        sts;
  logic [IDX_W-1:0] idx;
  logic [31:0]      scan_interval;
  logic [31:0]      safe_gap_limit;
  logic [3:0]       o_entity;
  logic [47:0]      o_overdue;
  logic [47:0]      o_lag;
  logic             o_safe;

  assign in_accept  = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;

  hdsc_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .scan_interval  (scan_interval),
    .safe_gap_limit (safe_gap_limit)
  );

  hdsc_ctrl #(
    .SCAN_N (SCAN_N),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .idx       (idx)
  );

  hdsc_dp #(
    .SCAN_N    (SCAN_N),
    .IDX_W     (IDX_W),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_func        (in_tuser),
    .in_entity      (in_tdata[3:0]),
    .in_deadline    (in_tdata[51:4]),
    .in_now         (in_tdata[99:52]),
    .scan_interval  (scan_interval),
    .safe_gap_limit (safe_gap_limit),
    .cmd            (cmd),
    .idx            (idx),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (out_tuser),
    .out_entity     (o_entity),
    .out_overdue    (o_overdue),
    .out_lag        (o_lag),
    .out_safe       (o_safe),
    .out_last       (out_tlast)
  );

  // result beat packing
  assign out_tdata = {3'b000, o_safe, o_lag, o_overdue, o_entity};

endmodule

// ===== bench/tb_heartbeat_deadline_scanner.sv =====
`timescale 1ns / 1ps
module tb_heartbeat_deadline_scanner;
  import hdsc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [47:0] TIME_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] TIME_MIN = 48'sh8000_0000_0000;
  localparam longint TIME_MAX_L = 64'sh0000_7FFF_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_ENT = 16;

  typedef longint unsigned u64_t;

  // one result beat as seen on the output stream
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  ent;
    logic [47:0] overdue;
    logic [47:0] lag;
    logic        safe;
    logic        last;
  } beat_t;

  // deadline table predictor and store of pending result beats
  class scan_scoreboard;
    logic [31:0]        interval_reg;
    logic [31:0]        gap_limit_reg;
    logic signed [47:0] deadline_tab[NUM_ENT];
    bit                 valid_tab[NUM_ENT];
    logic signed [47:0] last_scan;
    bit                 safe_latched;
    beat_t              pending[$];
    int                 errors;

    function void reset_state();
      interval_reg  = SCAN_INTERVAL_RST;
      gap_limit_reg = SAFE_GAP_LIMIT_RST;
      foreach (valid_tab[i]) begin
        valid_tab[i]    = 1'b0;
        deadline_tab[i] = '0;
      end
      last_scan    = '0;
      safe_latched = 1'b0;
      pending.delete();
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void push_beat(logic [1:0] st, logic [3:0] ent, longint od, longint lag,
                            logic safe, logic last);
      beat_t b;
      b.status  = st;
      b.ent     = ent;
      b.overdue = od[47:0];
      b.lag     = lag[47:0];
      b.safe    = safe;
      b.last    = last;
      pending = {pending, b};
    endfunction

    // apply one accepted input beat and queue the beats it should cause
    function void note_item(logic [1:0] func, logic [3:0] ent, logic signed [47:0] dl,
                            logic signed [47:0] now);
      longint t;
      longint gap;
      longint od;
      longint lag;
      int     i;
      case (func)
        FUNC_RECORD: begin
          deadline_tab[ent] = dl;
          valid_tab[ent]    = 1'b1;
        end
        FUNC_CLEAR: begin
          valid_tab[ent] = 1'b0;
        end
        FUNC_TICK: begin
          t   = now;
          lag = 0;
          if (t <= 0) begin
            push_beat(ST_INVALID, '0, '0, '0, safe_latched, 1'b1);
            return;
          end
          if (safe_latched) begin
            push_beat(ST_OVERDUE, '0, '0, '0, 1'b1, 1'b1);
            return;
          end
          // lag and gap check only once a scan has been stored
          if (last_scan > 0) begin
            gap = t - longint'(last_scan);
            if (gap > longint'(interval_reg)) lag = gap - longint'(interval_reg);
            if (lag > longint'(OUT_MAX)) lag = longint'(OUT_MAX);
            if (gap > longint'(gap_limit_reg)) begin
              safe_latched = 1'b1;
              push_beat(ST_OVERDUE, '0, '0, lag, 1'b1, 1'b1);
              return;
            end
          end
          for (i = 0; i < NUM_ENT; i++) begin
            if (valid_tab[i] && t >= longint'(deadline_tab[i])) begin
              od = t - longint'(deadline_tab[i]);
              if (u64_t'(od) > u64_t'(OUT_MAX)) od = longint'(OUT_MAX);
              push_beat(ST_DUE, i[3:0], od, lag, 1'b0, 1'b0);
            end
          end
          push_beat(ST_DONE, '0, '0, lag, 1'b0, 1'b1);
          last_scan = now;
        end
        default: ;
      endcase
    endfunction

    // compare one output beat with the oldest pending one
    function void check_beat(beat_t got);
      beat_t exp;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected beat st=%0d ent=%0d od=%h lag=%h safe=%b last=%b",
                       got.status, got.ent, got.overdue, got.lag, got.safe, got.last));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.ent !== exp.ent || got.overdue !== exp.overdue ||
          got.lag !== exp.lag || got.safe !== exp.safe || got.last !== exp.last)
        flag($sformatf({"exp st=%0d ent=%0d od=%h lag=%h safe=%b last=%b, ",
                        "got st=%0d ent=%0d od=%h lag=%h safe=%b last=%b"},
                       exp.status, exp.ent, exp.overdue, exp.lag, exp.safe, exp.last,
                       got.status, got.ent, got.overdue, got.lag, got.safe, got.last));
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;  // entity[3:0], deadline_time[51:4], now_time[99:52]
  logic [1:0]   in_tuser;  // func[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata; // due_entity[3:0], overdue_by[51:4], scan_lag[99:52], safe_mode[100]
  logic [1:0]   out_tuser; // status[1:0]
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  scan_scoreboard sb;
  bit             quiet_phase;
  int             stall_left;
  int             idle_cycles;
  beat_t          mon_beat;

  heartbeat_deadline_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side backpressure in bursts
  initial begin
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_phase) begin
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      mon_beat.status  = out_tuser;
      mon_beat.ent     = out_tdata[3:0];
      mon_beat.overdue = out_tdata[51:4];
      mon_beat.lag     = out_tdata[99:52];
      mon_beat.safe    = out_tdata[100];
      mon_beat.last    = out_tlast;
      sb.check_beat(mon_beat);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[heartbeat_deadline_scanner] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic longint rand_upto(longint span);
    u64_t r;
    r = {$urandom, $urandom};
    return longint'(r % (u64_t'(span) + 1));
  endfunction

  function automatic longint time_base();
    if (sb.last_scan > 0) return longint'(sb.last_scan);
    return 1000;
  endfunction

  // tick time near the last scan (some zero or negative), kept inside the gap limit unless in the last phase
  function automatic logic signed [47:0] pick_now(bit final_phase);
    longint      base;
    longint      span;
    longint      off;
    longint      t;
    logic [47:0] r48;
    int          r;
    base = (sb.last_scan > 0) ? longint'(sb.last_scan) : 1 + longint'($urandom_range(0, 3000));
    r = $urandom_range(0, 99);
    r48 = rand48();
    if (r < 3) return '0;
    if (r < 12) return {1'b1, r48[46:0]};
    if (r < 20) begin
      t = base - longint'($urandom_range(1, 5000));
    end else if (final_phase) begin
      t = base + longint'($urandom_range(0, 20));
    end else begin
      span = longint'(sb.gap_limit_reg);
      case ($urandom_range(0, 4))
        0: off = longint'(sb.interval_reg);
        1: off = longint'(sb.interval_reg) + 1;
        2: off = span;
        default: begin
          if (span < 3 * longint'(sb.interval_reg) + 50) off = rand_upto(span);
          else off = rand_upto(3 * longint'(sb.interval_reg) + 50);
        end
      endcase
      if (off > span) off = span;
      t = base + off;
    end
    if (t > TIME_MAX_L) t = TIME_MAX_L;
    return t[47:0];
  endfunction

  // drive one input beat and hand it to the predictor once taken
  task automatic send_item(input logic [1:0] func, input logic [3:0] ent,
                           input logic signed [47:0] dl, input logic signed [47:0] now);
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {4'b0, now, dl, ent};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(func, ent, dl, now);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic addr_bit, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {addr_bit, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic verify_regs();
    logic [31:0] rd;
    apb_xfer(1'b0, REG_SCAN_INTERVAL, '0, rd);
    if (rd !== sb.interval_reg)
      sb.flag($sformatf("scan_interval read exp=%h got=%h", sb.interval_reg, rd));
    apb_xfer(1'b0, REG_SAFE_GAP_LIMIT, '0, rd);
    if (rd !== sb.gap_limit_reg)
      sb.flag($sformatf("safe_gap_limit read exp=%h got=%h", sb.gap_limit_reg, rd));
  endtask

  task automatic set_config(input logic [31:0] iv, input logic [31:0] lim);
    logic [31:0] rd;
    apb_xfer(1'b1, REG_SCAN_INTERVAL, iv, rd);
    sb.interval_reg = iv;
    apb_xfer(1'b1, REG_SAFE_GAP_LIMIT, lim, rd);
    sb.gap_limit_reg = lim;
    verify_regs();
  endtask

  // mostly records, clears and in-range ticks, with some noise
  task automatic run_items(input int n, input bit final_phase);
    int          r;
    logic [47:0] dl;
    longint      d;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 6) == 0) begin
          dl = rand48();
        end else begin
          d  = time_base() + longint'($urandom_range(0, 6000)) - 3000;
          dl = d[47:0];
        end
        send_item(FUNC_RECORD, 4'($urandom_range(0, 15)), dl, rand48());
      end else if (r < 52) begin
        send_item(FUNC_CLEAR, 4'($urandom_range(0, 15)), rand48(), rand48());
      end else if (r < 57) begin
        send_item(FUNC_UNUSED, 4'($urandom_range(0, 15)), rand48(), rand48());
      end else begin
        send_item(FUNC_TICK, 4'($urandom_range(0, 15)), rand48(), pick_now(final_phase));
      end
    end
  endtask

  initial begin
    logic [31:0] iv;
    sb = new();
    sb.reset_state();
    quiet_phase = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FUNC_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    verify_regs();

    // directed: non-positive times before any scan, ignored selector
    send_item(FUNC_TICK, 4'd0, rand48(), 48'sd0);
    send_item(FUNC_TICK, 4'd9, rand48(), TIME_MIN);
    send_item(FUNC_TICK, 4'd0, '0, -48'sd1);
    send_item(FUNC_UNUSED, 4'd15, rand48(), rand48());
    // deadlines at the extremes, a cleared entry and a never written one
    send_item(FUNC_RECORD, 4'd0, TIME_MIN, rand48());
    send_item(FUNC_RECORD, 4'd15, TIME_MAX, '0);
    send_item(FUNC_RECORD, 4'd5, 48'sd100, '0);
    send_item(FUNC_RECORD, 4'd7, 48'sd500, '0);
    send_item(FUNC_CLEAR, 4'd7, '0, '0);
    send_item(FUNC_CLEAR, 4'd3, rand48(), rand48());
    // first scan at the largest time: widest overdue, no lag
    send_item(FUNC_TICK, 4'd0, '0, TIME_MAX);
    // going back in time, then lag around the interval and gap at the limit
    send_item(FUNC_TICK, 4'd0, '0, 48'sd100);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd1137);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd1137);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd2137);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd3138);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd8138);
    send_item(FUNC_TICK, 4'd0, '0, 48'sd1);
    send_item(FUNC_CLEAR, 4'd0, '0, '0);
    send_item(FUNC_CLEAR, 4'd15, '0, '0);

    // random phases over several register settings
    wait_drained();
    set_config(32'd1, 32'hFFFF_FFFF);
    run_items(45, 1'b0);
    wait_drained();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_items(45, 1'b0);
    wait_drained();
    iv = $urandom_range(1, 3000);
    set_config(iv, iv + $urandom_range(0, 6000));
    run_items(45, 1'b0);
    wait_drained();
    set_config(SCAN_INTERVAL_RST, SAFE_GAP_LIMIT_RST);
    run_items(45, 1'b0);
    // tightest gap limit: safe mode latches and stays, no idling from here on
    wait_drained();
    set_config($urandom_range(1, 50), 32'd1);
    quiet_phase = 1'b1;
    run_items(60, 1'b1);

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[heartbeat_deadline_scanner] OK");
    end else begin
      $display("[heartbeat_deadline_scanner] ERROR");
    end
    $finish;
  end

endmodule
